// ----- rtl/insertion_sorter_defines.svh -----
// Assertion macros for the insertion sorter.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define ISORT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a non-overlapping implication from a condition to a property.
`define ISORT_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/isort_pkg.sv -----
// Shared types and constants for the insertion sorter.
package isort_pkg;

   localparam int ISORT_MAX_ITEMS = 64;
   localparam int ISORT_DATA_W    = 32;

   typedef logic signed [ISORT_DATA_W-1:0] isort_word_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } isort_state_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic shift;
   } isort_ctrl_type;

endpackage

// ----- rtl/isort_cell.sv -----
// One compare-and-shift cell of the sorting chain.
module isort_cell (
   input  logic                     clock,
   input  isort_pkg::isort_ctrl_type ctrl,
   input  logic                     occupied,
   input  isort_pkg::isort_word_type new_value,
   input  isort_pkg::isort_word_type left_value,
   input  logic                     left_gt,
   input  isort_pkg::isort_word_type right_value,
   output isort_pkg::isort_word_type value,
   output logic                     gt
);

   isort_pkg::isort_word_type value_ff;
   isort_pkg::isort_word_type value_in;

   // Empty cells act as plus infinity so the new value lands after the tail.
   assign gt = !occupied || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && gt) begin
         value_in = left_gt ? left_value : new_value;
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- rtl/insertion_sorter.sv -----
// Top level of the streaming insertion sorter: cell chain plus control.
//
// Channel  Dir  Payload                                  Handshake
// req_     in   tdata[31:0] value, tlast last            tvalid/tready
// rsp_     out  tdata[31:0] sorted_value, tlast final,   tvalid/tready
//               tuser overflowed
//
// Each request is inserted when taken: every cell compares against the new
// value in parallel and the greater ones move up one place from their left
// neighbor. After the request marked last, the chain drains one result per
// cycle from cell 0 while rsp_tready is high, and requests are held off
// (req_tready low) while draining.
// Reset (synchronous, active high) clears the count, drop flag and state only.
// A stalled rsp_tready freezes the chain and holds the current result.
`include "insertion_sorter_defines.svh"

module insertion_sorter #(
   parameter int MAX_ITEMS = isort_pkg::ISORT_MAX_ITEMS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,   // final_res
   output logic        rsp_tuser    // [0] overflowed
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   isort_pkg::isort_state_type state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       dropped_ff, dropped_in;

   isort_pkg::isort_ctrl_type  ctrl;
   isort_pkg::isort_word_type  new_value;
   isort_pkg::isort_word_type  cell_value [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]       cell_gt;

   logic req_fire;
   logic rsp_fire;
   logic full;
   logic last_out;

   assign new_value = $signed(req_tdata);
   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign last_out  = (count_ff == CNT_W'(1));
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;

   // Insert unless full; shift the chain down on each taken result.
   always_comb begin
      ctrl.insert = req_fire && !full;
      ctrl.shift  = rsp_fire;
   end

   // Row of cells: cell g takes from g-1 on insert and from g+1 on drain.
   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      isort_pkg::isort_word_type left_v;
      isort_pkg::isort_word_type right_v;
      logic                      left_g;

      if (g == 0) begin : g_head
         assign left_v = '0;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_v = cell_value[g-1];
         assign left_g = cell_gt[g-1];
      end

      if (g == MAX_ITEMS - 1) begin : g_tail
         assign right_v = '0;
      end else begin : g_body
         assign right_v = cell_value[g+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > CNT_W'(g)),
         .new_value   (new_value),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .value       (cell_value[g]),
         .gt          (cell_gt[g])
      );
   end

   // Next state: drain after the last request, refill after the final result.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isort_pkg::ST_FILL: begin
            if (req_fire && req_tlast) begin
               state_in = isort_pkg::ST_DRAIN;
            end
         end
         isort_pkg::ST_DRAIN: begin
            if (rsp_fire && last_out) begin
               state_in = isort_pkg::ST_FILL;
            end
         end
         default: begin
            state_in = isort_pkg::ST_FILL;
         end
      endcase
   end

   // Outputs by state.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         isort_pkg::ST_FILL: begin
            req_tready = 1'b1;
         end
         isort_pkg::ST_DRAIN: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Count and drop flag.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rsp_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (req_fire && full) begin
         dropped_in = 1'b1;
      end else if (rsp_fire && last_out) begin
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= isort_pkg::ST_FILL;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_tdata = cell_value[0];
   assign rsp_tlast = last_out;
   assign rsp_tuser = dropped_ff;

   `ISORT_ASSERT(a_count_bound, (count_ff <= CNT_W'(MAX_ITEMS)), "count above capacity")
   `ISORT_ASSERT(a_drain_nonempty, (state_ff != isort_pkg::ST_DRAIN || count_ff != '0), "draining an empty chain")
   `ISORT_ASSERT_NEXT(a_final_clears, rsp_fire && rsp_tlast, (count_ff == '0 && !dropped_ff), "set not cleared after final result")
   `ISORT_ASSERT_NEXT(a_insert_count, ctrl.insert, (count_ff == $past(count_ff) + CNT_W'(1)), "insert did not advance count")

endmodule

// ----- tb/isort_run_checker.sv -----
// Scoreboard for the insertion sorter: predicts every sorted run and compares the responses.
module isort_run_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] value
   input  logic        req_tlast,    // last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // [31:0] sorted_value
   input  logic        rsp_tlast,    // final_res
   input  logic        rsp_tuser,    // [0] overflowed
   output int          mismatch_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      isort_pkg::isort_word_type sorted_value;
      logic                      final_res;
      logic                      overflowed;
   } sorted_entry_type;

   isort_pkg::isort_word_type held_values[isort_pkg::ISORT_MAX_ITEMS];
   int                        held_count;
   logic                      set_dropped;
   sorted_entry_type          sorted_run_q[$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      held_count      = 0;
      set_dropped     = 1'b0;
   end

   // Insert one value; strictly greater values move up, equal ones stay below.
   task automatic insert_value(input isort_pkg::isort_word_type value);
      int pos;
      pos = held_count;
      while (pos > 0 && held_values[pos-1] > value) begin
         held_values[pos] = held_values[pos-1];
         pos--;
      end
      held_values[pos] = value;
      held_count++;
   endtask

   always @(posedge clock) begin
      sorted_entry_type want;
      if (reset) begin
         held_count  = 0;
         set_dropped = 1'b0;
         sorted_run_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_run_q.size() == 0) begin
               $error("unexpected response: sorted_value %0d", $signed(rsp_tdata));
               mismatch_count++;
            end else begin
               want = sorted_run_q.pop_front();
               if ($signed(rsp_tdata) != want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                         $signed(rsp_tdata));
                  mismatch_count++;
               end
               if (rsp_tlast !== want.final_res) begin
                  $error("final_res: expected %0b, got %0b", want.final_res, rsp_tlast);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.overflowed) begin
                  $error("overflowed: expected %0b, got %0b", want.overflowed, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (held_count < isort_pkg::ISORT_MAX_ITEMS)
               insert_value(isort_pkg::isort_word_type'(req_tdata));
            else
               set_dropped = 1'b1;
            if (req_tlast) begin
               for (int k = 0; k < held_count; k++) begin
                  want.sorted_value = held_values[k];
                  want.final_res    = (k == held_count - 1);
                  want.overflowed   = set_dropped;
                  sorted_run_q.push_back(want);
               end
               held_count  = 0;
               set_dropped = 1'b0;
            end
         end
      end
      pending_results = sorted_run_q.size();
   end

endmodule

// ----- tb/tb_insertion_sorter.sv -----
// Testbench top for the insertion sorter: clock, reset, request stimulus and verdict.
module tb_insertion_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int PHASE_ITEMS  = 85;         // random requests per idling phase
   localparam int HOLD_CYCLES  = 400;        // long receiver hold-off
   localparam int SETTLE       = 2 * isort_pkg::ISORT_MAX_ITEMS + 20;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int                        mismatch_count;
   int                        pending_results;
   int                        cycle_count = 0;
   int                        hold_count = 0;
   logic                      long_hold = 1'b0;
   idle_mode_type             idle_mode = IDLE_NONE;
   isort_pkg::isort_word_type set_values[$];

   always #HALF_PERIOD clock = ~clock;

   insertion_sorter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   isort_run_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[insertion_sorter] ERROR");
         $finish;
      end
   end

   // Receiver: hold off for a long stretch once asked, otherwise stall at the
   // phase's rate. The hold counts its own cycles so the sender keeps offering
   // requests while the sorter fills, drains into a blocked output and backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold && hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_count++;
      end else begin
         case (idle_mode)
            IDLE_RECV: begin
               rsp_tready <= ($urandom_range(99, 0) >= 68);
            end
            IDLE_BOTH: begin
               rsp_tready <= ($urandom_range(99, 0) >= 37);
            end
            default: begin
               rsp_tready <= 1'b1;
            end
         endcase
      end
   end

   // Idle the sender at the phase's rate. The gap starts on a falling edge and
   // the step sees only one assignment to req_tvalid.
   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(99, 0) < 68;
         IDLE_BOTH: return $urandom_range(99, 0) < 37;
         default:   return 1'b0;
      endcase
   endfunction

   // Offer one request and hold it until the sorter takes it. Enter and leave
   // on a falling edge, so back-to-back requests keep tvalid high.
   task automatic send_item(input isort_pkg::isort_word_type value, input logic last);
      while (sender_idles()) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tlast  <= $urandom_range(1, 0);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Send the queued set, marking its final element.
   task automatic send_set();
      foreach (set_values[i])
         send_item(set_values[i], i == set_values.size() - 1);
   endtask

   // Mix extremes, a narrow band that forces duplicates, and full-range words.
   function automatic isort_pkg::isort_word_type pick_value();
      case ($urandom_range(7, 0))
         0: begin
            case ($urandom_range(4, 0))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               2:       return 32'sd0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1, 2:    return isort_pkg::isort_word_type'($signed($urandom_range(16, 0)) - 8);
         default: return isort_pkg::isort_word_type'($urandom);
      endcase
   endfunction

   // Random sets for one idling phase; the caller gives the first set's length,
   // which can force the full store or the dropped case.
   task automatic run_phase(input idle_mode_type mode, input int first_len);
      int sent;
      int len;
      idle_mode = mode;
      sent = 0;
      len  = first_len;
      while (sent < PHASE_ITEMS) begin
         set_values.delete();
         repeat (len) set_values.push_back(pick_value());
         send_set();
         sent += len;
         if ($urandom_range(11, 0) == 0)
            len = $urandom_range(isort_pkg::ISORT_MAX_ITEMS + 8,
                                 isort_pkg::ISORT_MAX_ITEMS - 4);
         else
            len = $urandom_range(12, 1);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets: single-element runs at both extremes, mixed extremes,
      // duplicates, a descending run and alternating bit patterns.
      set_values = '{32'sh7fff_ffff};
      send_set();
      set_values = '{32'sh8000_0000};
      send_set();
      set_values = '{32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000, 32'sh7fff_ffff};
      send_set();
      set_values = '{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3};
      send_set();
      set_values = '{32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1};
      send_set();
      set_values = '{32'sh5555_5555, 32'shaaaa_aaaa};
      send_set();

      // Hold the receiver off during a full set and the requests behind it.
      long_hold = 1'b1;
      run_phase(IDLE_NONE, isort_pkg::ISORT_MAX_ITEMS);
      run_phase(IDLE_SEND, isort_pkg::ISORT_MAX_ITEMS + $urandom_range(6, 1));
      run_phase(IDLE_RECV, $urandom_range(isort_pkg::ISORT_MAX_ITEMS + 8,
                                          isort_pkg::ISORT_MAX_ITEMS - 2));
      run_phase(IDLE_BOTH, $urandom_range(12, 1));
      run_phase(IDLE_NONE, $urandom_range(12, 1));
      req_tvalid <= 1'b0;

      // Drain every expected result, then let the chain settle.
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      if (pending_results != 0)
         $error("%0d sorted results never arrived", pending_results);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("[insertion_sorter] OK");
      end else begin
         $display("[insertion_sorter] ERROR");
      end
      $finish;
   end

endmodule
